>>> rtl/hpfc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Binary16 format converter package
// Request and result payload types, mode codes and a shared helper function.
// ----------------------------------------------------------------------------
package hpfc_pkg;

  // Conversion mode codes held in the mode register.
  typedef enum logic [2:0] {
    MODE_S8_TO_F16  = 3'd0,
    MODE_U8_TO_F16  = 3'd1,
    MODE_S32_TO_F16 = 3'd2,
    MODE_F32_TO_F16 = 3'd3,
    MODE_F16_TO_S8  = 3'd4,
    MODE_F16_TO_U8  = 3'd5,
    MODE_F16_TO_F32 = 3'd6,
    MODE_F16_TO_S32 = 3'd7
  } mode_t;

  typedef struct packed {
    logic [31:0] source_bits;
    logic        last_element;
  } request_t;

  typedef struct packed {
    logic [31:0] result_bits;
    logic        result_last;
  } result_t;

  // Position of the leading one in a 32-bit word (0 when the word is zero).
  function automatic logic [4:0] lead_one32(input logic [31:0] v);
    logic [4:0] p;
    p = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) p = 5'(i);
    end
    return p;
  endfunction

endpackage
`default_nettype wire

>>> rtl/half_precision_format_converter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Binary16 format converter
// Converts one element per request between binary16 and another type.
// ----------------------------------------------------------------------------
// A result strobes on done once its request has passed the request and result registers.
// Throughput: one request per cycle; busy stays low, set by the single
// pass of rounding logic between the request and result registers.
// Reset: synchronous; clears the mode register to s8->f16 and the valids.
// The receiver cannot stall; each result is shown for one cycle.
module half_precision_format_converter
  import hpfc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  output logic          busy,
  input  wire request_t request,
  output logic          done,
  output result_t       result,
  input  wire logic     cfg_we,
  input  wire logic [2:0] cfg_wdata
);

  mode_t       mode;
  request_t    req_q;
  logic        req_valid;
  logic [15:0] to_half;
  logic [31:0] from_half;
  logic [31:0] conv;

  assign busy = 1'b0;

  // Mode register.
  always_ff @(posedge clk) begin
    if (rst) mode <= MODE_S8_TO_F16;
    else if (cfg_we) mode <= mode_t'(cfg_wdata);
  end

  // Request register.
  always_ff @(posedge clk) begin
    if (rst) req_valid <= 1'b0;
    else req_valid <= start;
    req_q <= request;
  end

  hpfc_to_half u_to_half (
    .mode (mode),
    .src  (req_q.source_bits),
    .half (to_half)
  );

  hpfc_from_half u_from_half (
    .mode   (mode),
    .h      (req_q.source_bits[15:0]),
    .result (from_half)
  );

  // Pick the path by the mode's direction bit.
  assign conv = mode[2] ? from_half : {16'd0, to_half};

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= req_valid;
    result.result_bits <= conv;
    result.result_last <= req_q.last_element;
  end

  // Every taken request yields a strobe on done, through the request and result registers.
  assert property (@(posedge clk) disable iff (rst) start |-> ##2 done)
    else $error("request did not produce a result");
  // No result without a request.
  assert property (@(posedge clk) disable iff (rst) $rose(done) |-> $past(start, 2))
    else $error("result without request");
  // Narrow integer results are zero-extended.
  assert property (@(posedge clk) disable iff (rst)
    (req_valid && (mode == MODE_F16_TO_S8 || mode == MODE_F16_TO_U8)) |=>
    (result.result_bits[31:8] == 24'd0))
    else $error("narrow result not zero-extended");

endmodule
`default_nettype wire

>>> rtl/hpfc_to_half.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Conversion into binary16
// Rounds an integer or binary32 element to binary16, nearest even.
// ----------------------------------------------------------------------------
module hpfc_to_half
  import hpfc_pkg::*;
(
  input  wire mode_t       mode,
  input  wire logic [31:0] src,
  output logic [15:0]      half
);

  logic        sign;
  logic [31:0] mag;
  logic signed [9:0] e;    // value = mag * 2^e
  logic        special;
  logic [15:0] special_val;
  logic [4:0]  p;
  logic signed [10:0] shift;
  logic [31:0] q;
  logic [31:0] rem;
  logic [31:0] halfw;
  logic [31:0] mask;
  logic [5:0]  sh;
  logic signed [10:0] u;
  logic        rnd_up;

  // Unpack the source into sign, magnitude and scale.
  always_comb begin
    sign        = 1'b0;
    mag         = 32'd0;
    e           = 10'sd0;
    special     = 1'b0;
    special_val = 16'd0;
    unique case (mode)
      MODE_S8_TO_F16: begin
        sign = src[7];
        mag  = {24'd0, src[7] ? 8'(-src[7:0]) : src[7:0]};
      end
      MODE_U8_TO_F16: begin
        mag = {24'd0, src[7:0]};
      end
      MODE_S32_TO_F16: begin
        sign = src[31];
        mag  = src[31] ? -src : src;
      end
      default: begin
        sign = src[31];
        if (src[30:23] == 8'hFF) begin
          special     = 1'b1;
          special_val = (src[22:0] == 23'd0) ? {src[31], 15'h7C00} :
                        {src[31], 5'h1F, 1'b1, src[21:13]};
        end else if (src[30:23] == 8'd0) begin
          mag = {9'd0, src[22:0]};
          e   = -10'sd149;
        end else begin
          mag = {8'd0, 1'b1, src[22:0]};
          e   = 10'(signed'({2'b00, src[30:23]})) - 10'sd150;
        end
      end
    endcase
  end

  // Align to an 11-bit significand, round, and pack.
  always_comb begin
    p     = lead_one32(mag);
    shift = 11'(signed'({6'd0, p})) - 11'sd10;
    if ((-11'sd24 - 11'(e)) > shift) shift = -11'sd24 - 11'(e);
    q      = 32'd0;
    rem    = 32'd0;
    halfw  = 32'd0;
    mask   = 32'd0;
    rnd_up = 1'b0;
    sh     = 6'd0;
    if (shift >= 11'sd32) begin
      q = 32'd0;
    end else if (shift > 11'sd0) begin
      sh     = 6'(shift);
      mask   = (32'd1 << sh) - 32'd1;
      rem    = mag & mask;
      halfw  = 32'd1 << (sh - 6'd1);
      q      = mag >> sh;
      rnd_up = (rem > halfw) || ((rem == halfw) && q[0]);
      q      = q + {31'd0, rnd_up};
    end else begin
      sh = 6'(-shift);
      q  = mag << sh;
    end
    u = 11'(e) + shift;
    if (q >= 32'd2048) begin
      q = q >> 1;
      u = u + 11'sd1;
    end
    if (special) half = special_val;
    else if (mag == 32'd0 || q == 32'd0) half = {sign, 15'd0};
    else if (q < 32'd1024) half = {sign, 5'd0, q[9:0]};
    else if (u + 11'sd25 >= 11'sd31) half = {sign, 15'h7C00};
    else half = {sign, 5'(u + 11'sd25), q[9:0]};
  end

endmodule
`default_nettype wire

>>> rtl/hpfc_from_half.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Conversion from binary16
// Widens binary16 to binary32, or truncates it to a saturated integer.
// ----------------------------------------------------------------------------
module hpfc_from_half
  import hpfc_pkg::*;
(
  input  wire mode_t       mode,
  input  wire logic [15:0] h,
  output logic [31:0]      result
);

  logic        sign;
  logic [4:0]  ex;
  logic [9:0]  mant;
  logic [31:0] single;
  logic [3:0]  p;
  logic [4:0]  p5;
  logic [31:0] mag;
  logic [31:0] sval;
  logic        nan;
  logic        inf;

  assign sign = h[15];
  assign ex   = h[14:10];
  assign mant = h[9:0];
  assign nan  = (ex == 5'h1F) && (mant != 10'd0);
  assign inf  = (ex == 5'h1F) && (mant == 10'd0);

  // Widening to binary32, subnormals normalized.
  always_comb begin
    p5 = lead_one32({22'd0, mant});
    p  = p5[3:0];
    if (ex == 5'h1F) begin
      single = inf ? {sign, 31'h7F800000} : {sign, 8'hFF, 1'b1, mant[8:0], 13'd0};
    end else if (ex == 5'd0) begin
      if (mant == 10'd0) single = {sign, 31'd0};
      else single = {sign, 8'(8'd103 + {4'd0, p}),
                     23'({13'd0, mant} << (5'd23 - {1'b0, p}))};
    end else begin
      single = {sign, 8'({3'd0, ex} + 8'd112), mant, 13'd0};
    end
  end

  // Truncated magnitude: zero for subnormals, infinities and NaNs, exact shift otherwise.
  always_comb begin
    if (ex == 5'd0 || ex == 5'h1F) mag = 32'd0;
    else if (ex >= 5'd25) mag = {21'd0, 1'b1, mant} << (ex - 5'd25);
    else mag = {21'd0, 1'b1, mant} >> (5'd25 - ex);
  end

  // Saturate into the target integer range, or pass the binary32 widening through.
  always_comb begin
    sval = 32'd0;
    unique case (mode)
      MODE_F16_TO_S8: begin
        if (nan) sval = 32'd0;
        else if (inf) sval = sign ? 32'h80 : 32'h7F;
        else if (sign) sval = (mag > 32'd128) ? 32'h80 : {24'd0, 8'(-mag)};
        else sval = (mag > 32'd127) ? 32'h7F : mag;
      end
      MODE_F16_TO_U8: begin
        if (nan || sign) sval = 32'd0;
        else if (inf) sval = 32'hFF;
        else sval = (mag > 32'd255) ? 32'hFF : mag;
      end
      MODE_F16_TO_S32: begin
        if (nan) sval = 32'd0;
        else if (inf) sval = sign ? 32'h80000000 : 32'h7FFFFFFF;
        else sval = sign ? -mag : mag;
      end
      default: sval = single;
    endcase
    result = sval;
  end

endmodule
`default_nettype wire
